/* src/las_pkg.sv */
`timescale 1ns / 1ps

package las_pkg;

  localparam int CFG_W     = 8;
  localparam int ROW_W     = 8;
  localparam int COL_OUT_W = 7;

  // smallest grid side that still has an interior cell
  localparam int GRID_MIN = 3;

  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [0:0]           cfg_idx_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [COL_OUT_W-1:0] col_out_t;

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam cfg_data_t GRID_WIDTH_RST  = 8'd120;
  localparam cfg_data_t GRID_HEIGHT_RST = 8'd80;

endpackage

/* src/las_stream_if.sv */
`timescale 1ns / 1ps

interface las_in_if;
  import las_pkg::*;

  logic valid;
  logic ready;
  logic cell_alive;
  logic first_of_frame;

  modport source (output valid, cell_alive, first_of_frame, input ready);
  modport sink   (input valid, cell_alive, first_of_frame, output ready);
endinterface

interface las_out_if;
  import las_pkg::*;

  logic     valid;
  logic     ready;
  logic     next_alive;
  row_t     out_row;
  col_out_t out_col;
  logic     last_of_frame;

  modport source (output valid, next_alive, out_row, out_col, last_of_frame, input ready);
  modport sink   (input valid, next_alive, out_row, out_col, last_of_frame, output ready);
endinterface

/* src/life_automaton_stream.sv */
`timescale 1ns / 1ps

// One generation of Life (B3/S23) over a grid with a dead border.
// cell_i carries the current generation one cell per request in raster
// order; first_of_frame restarts the position counters at row 0, column 0.
// res_o carries the next state of each interior cell, one row and one
// column behind the input, with its row, column and a last-of-frame flag.
// Border positions produce no request on res_o.
// grid_width and grid_height are written through the cfg port while the
// block is idle; out-of-range values are clamped to 3..MAX_COLUMNS and
// 3..255.
// A result is registered after its input is accepted: first in the
// line-store read register, then in the result register.
// Throughput: one cell per cycle unless a held result stalls it, set by
// the single read and write port of each line store used once per cell.
// After reset the line stores are cleared, one column per cycle, and
// cell_i.ready stays low until the last column is cleared.
// When res_o stalls, the pending result holds; cells that produce no
// result keep flowing, and cell_i.ready drops only once a result-bearing
// cell would have to wait behind the held one.
module life_automaton_stream #(
  parameter int MAX_COLUMNS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  las_pkg::cfg_idx_t  cfg_index_i,
  input  las_pkg::cfg_data_t cfg_data_i,
  las_in_if.sink            cell_i,
  las_out_if.source         res_o
);
  import las_pkg::*;

  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int WRAW = $clog2(MAX_COLUMNS + 1);
  localparam int UW   = (WRAW > CFG_W) ? WRAW : CFG_W;

  typedef logic [CW-1:0] col_t;
  typedef logic [UW-1:0] wide_t;

  typedef struct packed {
    col_t     col;
    row_t     row;
    logic     cur;
    logic     emit;
    logic     last;
    row_t     out_row;
    col_out_t out_col;
  } stage_t;

  typedef struct packed {
    logic     next_alive;
    row_t     out_row;
    col_out_t out_col;
    logic     last_of_frame;
  } result_t;

  // configuration
  cfg_data_t grid_width_q, grid_height_q;
  wide_t     w_used;
  row_t      h_used;

  // counters and clearing pass
  row_t  row_q, row_d;
  col_t  col_q, col_d;
  logic  clr_active_q;
  col_t  clr_addr_q;

  // line stores
  logic upper_mem  [MAX_COLUMNS];
  logic middle_mem [MAX_COLUMNS];
  logic up_rd_q, mid_rd_q;

  // pipeline
  logic    s1_valid_q, s1_adv;
  stage_t  s1_q, s1_d;
  logic [8:0] win_q, win_d;
  logic    out_valid_q;
  result_t out_q, out_d;

  logic  acc, fwd;
  row_t  row_base;
  col_t  col_base;
  wide_t col_ext, col_inc, col_m1;
  logic [ROW_W:0] row_inc;
  logic  border;
  logic [3:0] nbr_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (UW'(grid_width_q) < UW'(GRID_MIN)) begin
      w_used = UW'(GRID_MIN);
    end else if (UW'(grid_width_q) > UW'(MAX_COLUMNS)) begin
      w_used = UW'(MAX_COLUMNS);
    end else begin
      w_used = UW'(grid_width_q);
    end
    h_used = (grid_height_q < ROW_W'(GRID_MIN)) ? ROW_W'(GRID_MIN) : grid_height_q;
  end

  // handshake
  assign s1_adv       = s1_valid_q && (!s1_q.emit || !out_valid_q || res_o.ready);
  assign cell_i.ready = !clr_active_q && (!s1_valid_q || s1_adv);
  assign acc          = cell_i.valid && cell_i.ready;

  // position, border and emit decode of the accepted cell
  always_comb begin
    row_base = cell_i.first_of_frame ? '0 : row_q;
    col_base = cell_i.first_of_frame ? '0 : col_q;
    col_ext  = UW'(col_base);
    col_inc  = col_ext + UW'(1);
    col_m1   = col_ext - UW'(1);
    row_inc  = {1'b0, row_base} + (ROW_W+1)'(1);

    border = (row_base == '0) || (row_base >= h_used - ROW_W'(1)) ||
             (col_ext == '0) || (col_ext >= w_used - UW'(1));

    s1_d.col     = col_base;
    s1_d.row     = row_base;
    s1_d.cur     = cell_i.cell_alive && !border;
    s1_d.emit    = (row_base >= ROW_W'(2)) && (row_base <= h_used - ROW_W'(1)) &&
                   (col_ext >= UW'(2)) && (col_ext <= w_used - UW'(1));
    s1_d.last    = (row_base == h_used - ROW_W'(1)) && (col_ext == w_used - UW'(1));
    s1_d.out_row = row_base - ROW_W'(1);
    s1_d.out_col = col_m1[COL_OUT_W-1:0];

    if (col_inc >= w_used) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_used}) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = row_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // sweep both line stores to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + CW'(1);
      if (clr_addr_q == CW'(MAX_COLUMNS - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // same column written back this edge: take the values being written
  assign fwd = s1_adv && (s1_q.col == col_base);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      up_rd_q  <= fwd ? mid_rd_q : upper_mem[col_base];
      mid_rd_q <= fwd ? s1_q.cur : middle_mem[col_base];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      upper_mem[clr_addr_q]  <= 1'b0;
      middle_mem[clr_addr_q] <= 1'b0;
    end else if (s1_adv) begin
      upper_mem[s1_q.col]  <= mid_rd_q;
      middle_mem[s1_q.col] <= s1_q.cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // window: columns oldest to newest, each upper/middle/current from low bit
  always_comb begin
    logic [8:0] nbr;
    win_d = {s1_q.cur, mid_rd_q, up_rd_q, win_q[8:3]};
    nbr   = win_d & 9'h1EF;
    nbr_count = '0;
    for (int i = 0; i < 9; i++) begin
      nbr_count = nbr_count + 4'(nbr[i]);
    end
    out_d.next_alive    = (nbr_count == 4'd3) || ((nbr_count == 4'd2) && win_d[4]);
    out_d.out_row       = s1_q.out_row;
    out_d.out_col       = s1_q.out_col;
    out_d.last_of_frame = s1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.next_alive    = out_q.next_alive;
  assign res_o.out_row       = out_q.out_row;
  assign res_o.out_col       = out_q.out_col;
  assign res_o.last_of_frame = out_q.last_of_frame;

  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !cell_i.ready
  ) else $error("cell accepted during line store clear");

  a_frame_restart : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (acc && cell_i.first_of_frame) |=> (s1_q.row == '0 && s1_q.col == '0)
  ) else $error("frame restart did not reset position");

  a_col_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    UW'(col_q) < UW'(MAX_COLUMNS)
  ) else $error("column counter beyond line store depth");

  a_result_interior : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.out_row != '0)
  ) else $error("result emitted for a border row");

endmodule

/* verif/life_automaton_stream_test.sv */
`timescale 1ns / 1ps

module life_automaton_stream_test;
  import las_pkg::*;

  localparam int LIFE_COLS     = 128;
  localparam int LIFE_ROWS_MAX = 255;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_CELLS  = 650;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic     next_alive;
    row_t     row;
    col_out_t col;
    logic     last;
  } life_result_t;

  localparam life_result_t NO_RESULT = '0;

  typedef struct packed {
    logic         resize;
    cfg_data_t    width;
    cfg_data_t    height;
    logic         alive;
    logic         first;
    logic         typed;
    life_result_t want;
  } directed_row_t;

  // resize, width, height, cell, first, typed, typed result
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    // 3x3 grid: the center is the only interior cell and never has a live neighbor
    '{1'b1, 8'd3, 8'd3, 1'b1, 1'b1, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1, '{1'b0, 8'd1, 7'd1, 1'b1}},
    // 4x4 grid: a 2x2 block is a still life; live border inputs count as dead
    '{1'b1, 8'd4, 8'd4, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1, '{1'b1, 8'd1, 7'd1, 1'b0}},
    '{1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, '{1'b1, 8'd1, 7'd2, 1'b0}},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1, '{1'b1, 8'd2, 7'd1, 1'b0}},
    '{1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1, '{1'b1, 8'd2, 7'd2, 1'b1}}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  las_in_if  cell_if ();
  las_out_if res_if ();

  life_automaton_stream dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .cell_i      (cell_if.sink),
    .res_o       (res_if.source)
  );

  always #10 clk = ~clk;

  // Predictor state: line stores, 3x3 window, raster position, grid registers
  bit          upper_row_bits  [LIFE_COLS];
  bit          middle_row_bits [LIFE_COLS];
  logic [8:0]  window_bits;
  int unsigned row_pos;
  int unsigned col_pos;
  cfg_data_t   width_reg;
  cfg_data_t   height_reg;

  life_result_t pending_results [$];

  bit          steady;
  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned cells_sent;
  int unsigned random_sent;
  int unsigned settings_tried;
  int unsigned cycle_count;
  int unsigned stall_left;

  function automatic int unsigned grid_cols(cfg_data_t v);
    if (v < GRID_MIN) return GRID_MIN;
    if (v > LIFE_COLS) return LIFE_COLS;
    return v;
  endfunction

  function automatic int unsigned grid_rows(cfg_data_t v);
    if (v < GRID_MIN) return GRID_MIN;
    if (v > LIFE_ROWS_MAX) return LIFE_ROWS_MAX;
    return v;
  endfunction

  // Take one cell into the predictor; return 1 when an interior cell is emitted.
  function automatic bit advance_generation(input logic alive, input logic first,
                                            output life_result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned live;
    bit          border;
    bit          cur;
    bit          up;
    bit          mid;
    bit          produced;
    w = grid_cols(width_reg);
    h = grid_rows(height_reg);
    if (first) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (c >= LIFE_COLS) c = LIFE_COLS - 1;
    border = (r == 0) || (r >= h - 1) || (c == 0) || (c >= w - 1);
    cur = border ? 1'b0 : alive;
    up  = upper_row_bits[c];
    mid = middle_row_bits[c];
    upper_row_bits[c]  = mid;
    middle_row_bits[c] = cur;
    // newest column on top: current, middle, upper row
    window_bits = {cur, mid, up, window_bits[8:3]};
    res = NO_RESULT;
    produced = 1'b0;
    if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
      live = $countones(window_bits & 9'h1EF);
      res.next_alive = (live == 3) || (live == 2 && window_bits[4]);
      res.row  = row_t'(r - 1);
      res.col  = col_out_t'(c - 1);
      res.last = (r == h - 1) && (c == w - 1);
      produced = 1'b1;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return produced;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int unsigned idle_cycles();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cfg_data_t random_side(int unsigned typical_max);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return cfg_data_t'($urandom_range(0, GRID_MIN - 1));
    if (pick == 1) return cfg_data_t'($urandom_range(typical_max + 1, 255));
    return cfg_data_t'($urandom_range(GRID_MIN, typical_max));
  endfunction

  task automatic note_mismatch(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("MISMATCH %s", msg);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty.
  task automatic settle();
    cell_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(cfg_data_t w, cfg_data_t h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    width_reg = w;
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    height_reg = h;
    cfg_we <= 1'b0;
    settings_tried++;
  endtask

  task automatic send_cell(logic alive, logic first, logic typed, life_result_t want);
    int unsigned  gap;
    life_result_t predicted;
    bit           produced;
    gap = idle_cycles();
    if (gap > 0) begin
      cell_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_if.valid          <= 1'b1;
    cell_if.cell_alive     <= alive;
    cell_if.first_of_frame <= first;
    do @(posedge clk); while (!cell_if.ready);
    produced = advance_generation(alive, first, predicted);
    if (typed) pending_results.push_back(want);
    else if (produced) pending_results.push_back(predicted);
    cells_sent++;
  endtask

  // One grid setting: frames of random content, optionally continuing mid-frame.
  task automatic run_phase(cfg_data_t w, cfg_data_t h, int unsigned budget, bit restart);
    int unsigned frame;
    int unsigned count;
    int unsigned density;
    int unsigned k;
    logic        first;
    settle();
    set_grid(w, h);
    steady  = ($urandom_range(0, 3) == 0);
    density = $urandom_range(15, 85);
    frame   = grid_cols(w) * grid_rows(h);
    count   = frame * $urandom_range(1, 2);
    if (count > budget) count = budget;
    for (k = 0; k < count; k++) begin
      if (k % frame == 0) first = (k != 0) || restart;
      else first = ($urandom_range(0, 99) < 3);
      send_cell($urandom_range(0, 99) < density, first, 1'b0, NO_RESULT);
      random_sent++;
    end
  endtask

  always @(posedge clk) begin
    life_result_t got;
    life_result_t want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.next_alive, res_if.out_row, res_if.out_col, res_if.last_of_frame};
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result with nothing pending: row %0d col %0d alive %0d",
                                  got.row, got.col, got.next_alive));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.next_alive !== want.next_alive)
            note_mismatch($sformatf("next_alive at row %0d col %0d: expected %0d, got %0d",
                                    want.row, want.col, want.next_alive, got.next_alive));
          if (got.row !== want.row)
            note_mismatch($sformatf("out_row: expected %0d, got %0d", want.row, got.row));
          if (got.col !== want.col)
            note_mismatch($sformatf("out_col at row %0d: expected %0d, got %0d",
                                    want.row, want.col, got.col));
          if (got.last !== want.last)
            note_mismatch($sformatf("last_of_frame at row %0d col %0d: expected %0d, got %0d",
                                    want.row, want.col, want.last, got.last));
        end
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = idle_cycles();
      end
    end else begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_GRID_WIDTH;
    cfg_data               = '0;
    cell_if.valid          = 1'b0;
    cell_if.cell_alive     = 1'b0;
    cell_if.first_of_frame = 1'b0;
    steady                 = 1'b0;
    foreach (upper_row_bits[j]) begin
      upper_row_bits[j]  = 1'b0;
      middle_row_bits[j] = 1'b0;
    end
    window_bits = '0;
    row_pos     = 0;
    col_pos     = 0;
    width_reg   = GRID_WIDTH_RST;
    height_reg  = GRID_HEIGHT_RST;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < $size(DIRECTED_ROWS); i++) begin
      if (DIRECTED_ROWS[i].resize) begin
        settle();
        set_grid(DIRECTED_ROWS[i].width, DIRECTED_ROWS[i].height);
      end
      send_cell(DIRECTED_ROWS[i].alive, DIRECTED_ROWS[i].first,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // clamped registers at both ends, then a resize that lands mid-frame
    run_phase(8'd0, 8'd1, 36, 1'b1);
    run_phase(8'd255, 8'd3, 384, 1'b1);
    run_phase(8'd2, 8'd255, 60, 1'b1);
    run_phase(8'd128, 8'd255, 40, 1'b0);
    while (random_sent < RANDOM_CELLS)
      run_phase(random_side(12), random_side(10), 120, $urandom_range(0, 3) != 0);

    settle();
    $display("Streamed %0d cells (%0d directed) over %0d grid settings",
             cells_sent, $size(DIRECTED_ROWS), settings_tried);
    $display("Checked %0d next-generation results, %0d mismatches",
             results_checked, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
